/* hdl/hsl_pkg.sv */
`timescale 1ns / 1ps
package hsl_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int HW          = FRAC_BITS + 3;
  localparam int LVL_STAGES  = 4;
  localparam int CHAN_STAGES = 3;

  typedef logic [15:0]           pix_t;
  typedef logic [FRAC_BITS-1:0]  frac_t;
  typedef logic [HW-1:0]         hwide_t;
  typedef logic [FRAC_BITS:0]    step_t;
  typedef logic [FRAC_BITS+16:0] ramp_t;

  localparam pix_t   MAX16          = 16'hFFFF;
  localparam hwide_t HUE_ONE        = hwide_t'(1) << FRAC_BITS;
  localparam hwide_t HUE_TWO        = HUE_ONE << 1;
  localparam hwide_t HUE_THIRD      = (HUE_ONE + hwide_t'(1)) / hwide_t'(3);
  localparam hwide_t HUE_TWO_THIRDS = (HUE_TWO + hwide_t'(1)) / hwide_t'(3);
  localparam frac_t  THIRD_F        = HUE_THIRD[FRAC_BITS-1:0];
  localparam frac_t  NEG_THIRD_F    = frac_t'(HUE_ONE - HUE_THIRD);

  typedef enum logic [2:0] {
    SEG_RAMP = 3'b001,
    SEG_HIGH = 3'b010,
    SEG_LOW  = 3'b100
  } seg_t;

  typedef struct packed {
    logic [LVL_STAGES-1:0]  lvl;
    logic [CHAN_STAGES-1:0] chan;
  } pipe_en_t;

endpackage

/* hdl/hsl_level.sv */
`timescale 1ns / 1ps
module hsl_level (
  input  logic              clk,
  input  hsl_pkg::pipe_en_t en,
  input  hsl_pkg::pix_t     hue,
  input  hsl_pkg::pix_t     saturation,
  input  hsl_pkg::pix_t     lightness,
  output hsl_pkg::pix_t     p_level,
  output hsl_pkg::pix_t     q_level,
  output hsl_pkg::pix_t     light,
  output logic              is_gray,
  output hsl_pkg::frac_t    pos_red,
  output hsl_pkg::frac_t    pos_green,
  output hsl_pkg::frac_t    pos_blue
);
  import hsl_pkg::*;

  localparam logic [17:0] R_ONE = 18'(MAX16);
  localparam logic [17:0] R_TWO = R_ONE + R_ONE;

  // stage 1: product
  pix_t        h1, s1, l1;
  logic        dark1;
  logic [32:0] prod1;
  logic [16:0] mult;

  // stage 2: divide by full scale
  pix_t        h2, s2, l2;
  logic        dark2;
  logic [16:0] qdiv2;
  logic [16:0] q0;
  logic [17:0] rem;
  logic [16:0] qdiv;

  // stage 3: upper level
  pix_t        h3, s3, l3, q3;
  logic [17:0] qsum, qw;
  pix_t        q_sat;

  // stage 4: lower level and hue positions
  logic [16:0]          l_dbl, pw;
  pix_t                 p_c;
  logic [FRAC_BITS+15:0] hwide;
  frac_t                t;

  always_comb begin
    mult = (lightness < 16'h8000) ? 17'(MAX16) + 17'(saturation) : 17'(saturation);
  end

  always_ff @(posedge clk) begin
    if (en.lvl[0]) begin
      h1    <= hue;
      s1    <= saturation;
      l1    <= lightness;
      dark1 <= (lightness < 16'h8000);
      prod1 <= 33'(lightness) * 33'(mult);
    end
  end

  always_comb begin
    q0   = prod1[32:16];
    rem  = 18'(prod1[15:0]) + 18'(q0);
    qdiv = q0 + 17'(rem >= R_ONE) + 17'(rem >= R_TWO);
  end

  always_ff @(posedge clk) begin
    if (en.lvl[1]) begin
      h2    <= h1;
      s2    <= s1;
      l2    <= l1;
      dark2 <= dark1;
      qdiv2 <= qdiv;
    end
  end

  always_comb begin
    qsum  = 18'(l2) + 18'(s2) - 18'(qdiv2);
    qw    = dark2 ? 18'(qdiv2) : qsum;
    q_sat = (qw > 18'(MAX16)) ? MAX16 : qw[15:0];
  end

  always_ff @(posedge clk) begin
    if (en.lvl[2]) begin
      h3 <= h2;
      s3 <= s2;
      l3 <= l2;
      q3 <= q_sat;
    end
  end

  always_comb begin
    l_dbl = {l3, 1'b0};
    pw    = (l_dbl >= 17'(q3)) ? l_dbl - 17'(q3) : '0;
    p_c   = (pw > 17'(q3)) ? q3 : pw[15:0];
    hwide = {h3, {FRAC_BITS{1'b0}}};
    t     = hwide[FRAC_BITS+15:16];
  end

  always_ff @(posedge clk) begin
    if (en.lvl[3]) begin
      p_level   <= p_c;
      q_level   <= q3;
      light     <= l3;
      is_gray   <= (s3 == 16'h0000);
      pos_red   <= t + THIRD_F;
      pos_green <= t;
      pos_blue  <= t + NEG_THIRD_F;
    end
  end

endmodule

/* hdl/hsl_chan.sv */
`timescale 1ns / 1ps
module hsl_chan (
  input  logic              clk,
  input  hsl_pkg::pipe_en_t en,
  input  hsl_pkg::frac_t    pos,
  input  hsl_pkg::pix_t     p_level,
  input  hsl_pkg::pix_t     q_level,
  input  hsl_pkg::pix_t     light,
  input  logic              is_gray,
  output hsl_pkg::pix_t     level
);
  import hsl_pkg::*;

  // stage 5: segment pick and slope factor
  hwide_t x, x3, x6, span;
  seg_t   seg_c;
  step_t  k_c;
  pix_t   d5, p5, q5, l5;
  step_t  k5;
  seg_t   seg5;
  logic   gray5;

  // stage 6: ramp product
  ramp_t  prod6;
  pix_t   p6, q6, l6;
  seg_t   seg6;
  logic   gray6;

  // stage 7: final sum
  logic [17:0] rsum;
  pix_t        ramp_sat;

  always_comb begin
    x     = hwide_t'(pos);
    x3    = (x << 1) + x;
    x6    = x3 << 1;
    span  = (HUE_TWO_THIRDS >= x) ? HUE_TWO_THIRDS - x : '0;
    seg_c = SEG_LOW;
    k_c   = '0;
    if (x6 < HUE_ONE) begin
      seg_c = SEG_RAMP;
      k_c   = step_t'(x6);
    end else if (!pos[FRAC_BITS-1]) begin
      seg_c = SEG_HIGH;
    end else if (x3 < HUE_TWO) begin
      seg_c = SEG_RAMP;
      k_c   = step_t'((span << 2) + (span << 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en.chan[0]) begin
      d5    <= q_level - p_level;
      k5    <= k_c;
      seg5  <= seg_c;
      p5    <= p_level;
      q5    <= q_level;
      l5    <= light;
      gray5 <= is_gray;
    end
  end

  always_ff @(posedge clk) begin
    if (en.chan[1]) begin
      prod6 <= ramp_t'(d5) * ramp_t'(k5);
      seg6  <= seg5;
      p6    <= p5;
      q6    <= q5;
      l6    <= l5;
      gray6 <= gray5;
    end
  end

  always_comb begin
    rsum     = 18'(p6) + 18'(prod6[FRAC_BITS+16:FRAC_BITS]);
    ramp_sat = (rsum > 18'(MAX16)) ? MAX16 : rsum[15:0];
  end

  always_ff @(posedge clk) begin
    if (en.chan[2]) begin
      if (gray6) begin
        level <= l6;
      end else begin
        case (seg6)
          SEG_RAMP: level <= ramp_sat;
          SEG_HIGH: level <= q6;
          SEG_LOW:  level <= p6;
          default:  level <= p6;
        endcase
      end
    end
  end

endmodule

/* hdl/hsl_to_rgb_convert_unit.sv */
`timescale 1ns / 1ps
// HSL to RGB pixel converter.
// Pipeline: 4 level stages, then 3 channel stages, from input accept to output word.
// Throughput: one word per cycle while out_stall is low; per-stage valid bits let bubbles close under stall.
// Reset (rst, synchronous, active high) clears all stage valid bits; data regs are not reset.
module hsl_to_rgb_convert_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hsl_pkg::pix_t hue,
  input  hsl_pkg::pix_t saturation,
  input  hsl_pkg::pix_t lightness,
  output logic          out_valid,
  input  logic          out_stall,
  output hsl_pkg::pix_t red,
  output hsl_pkg::pix_t green,
  output hsl_pkg::pix_t blue
);
  import hsl_pkg::*;

  localparam int NSTG = LVL_STAGES + CHAN_STAGES;

  logic [NSTG:1]   vld;
  logic [NSTG:1]   vld_next;
  logic [NSTG+1:1] adv;
  pipe_en_t        en;

  pix_t  p_level, q_level, light;
  logic  is_gray;
  frac_t pos_red, pos_green, pos_blue;

  always_comb begin
    adv[NSTG+1] = !out_stall;
    for (int k = NSTG; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
    vld_next = {vld[NSTG-1:1], in_valid};
  end

  assign en.lvl    = adv[LVL_STAGES:1];
  assign en.chan   = adv[NSTG:LVL_STAGES+1];
  assign in_stall  = rst || !adv[1];
  assign out_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_next[k];
        end
      end
    end
  end

  hsl_level u_level (
    .clk        (clk),
    .en         (en),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .p_level    (p_level),
    .q_level    (q_level),
    .light      (light),
    .is_gray    (is_gray),
    .pos_red    (pos_red),
    .pos_green  (pos_green),
    .pos_blue   (pos_blue)
  );

  hsl_chan u_chan_red (
    .clk     (clk),
    .en      (en),
    .pos     (pos_red),
    .p_level (p_level),
    .q_level (q_level),
    .light   (light),
    .is_gray (is_gray),
    .level   (red)
  );

  hsl_chan u_chan_green (
    .clk     (clk),
    .en      (en),
    .pos     (pos_green),
    .p_level (p_level),
    .q_level (q_level),
    .light   (light),
    .is_gray (is_gray),
    .level   (green)
  );

  hsl_chan u_chan_blue (
    .clk     (clk),
    .en      (en),
    .pos     (pos_blue),
    .p_level (p_level),
    .q_level (q_level),
    .light   (light),
    .is_gray (is_gray),
    .level   (blue)
  );

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_stall && (&vld)) |-> in_stall)
    else $error("pipeline full and stalled but input not stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[1])
    else $error("accepted word missing from first stage");

  a_drain_moves: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !vld[NSTG-1]) |=> !out_valid)
    else $error("output word repeated after delivery");

endmodule
